FILE: hw/rtl/bmpd_pkg.sv
// bmpd_pkg: shared types, constants and helpers for the 24-bit bitmap decoder
// word layouts for the byte and result channels, parse modes, result kinds
// no dependencies

package bmpd_pkg;

    localparam logic [31:0] MAX_DIM      = 32'd16384;
    localparam int unsigned HEADER_BYTES = 54;
    localparam int unsigned WIDTH_OFS    = 18;
    localparam int unsigned HEIGHT_OFS   = 22;

    localparam logic [5:0] HDR_LAST   = 6'(HEADER_BYTES - 1);
    localparam logic [5:0] WIDTH_LO   = 6'(WIDTH_OFS);
    localparam logic [5:0] WIDTH_HI   = 6'(WIDTH_OFS + 4);
    localparam logic [5:0] HEIGHT_LO  = 6'(HEIGHT_OFS);
    localparam logic [5:0] HEIGHT_HI  = 6'(HEIGHT_OFS + 4);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        MODE_HEADER = 4'b0001,
        MODE_PIXEL  = 4'b0010,
        MODE_PAD    = 4'b0100,
        MODE_DONE   = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        PHASE_BLUE  = 2'd0,
        PHASE_GREEN = 2'd1,
        PHASE_RED   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] packed_color;
        logic [13:0] column;
        logic [13:0] row;
        logic        last_pixel;
        logic [14:0] image_width;
        logic [14:0] image_height;
    } out_word_t;

    // saturate a captured dimension for reporting
    function automatic logic [14:0] sat_dim(input logic [31:0] v);
        logic [14:0] s;
        if (v > MAX_DIM)
        begin
            s = MAX_DIM[14:0];
        end
        else
        begin
            s = v[14:0];
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/bmpd_in_if.sv
// bmpd_in_if: valid/ready channel carrying one file byte per word
// depends on bmpd_pkg for the word layout

interface bmpd_in_if;
    logic               valid;
    logic               ready;
    bmpd_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bmpd_out_if.sv
// bmpd_out_if: valid/ready channel carrying one decoder result per word
// depends on bmpd_pkg for the word layout

interface bmpd_out_if;
    logic                valid;
    logic                ready;
    bmpd_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bmpd_parse.sv
// bmpd_parse: byte parser state and per-byte next-state / result logic
// depends on bmpd_pkg and bmpd_in_if

module bmpd_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    bmpd_in_if.sink              bytes,
    input  logic                 space,
    output logic                 accept,
    output logic                 res_valid,
    output bmpd_pkg::out_word_t  res
);

    logic [5:0]       hc_reg,     hc_next;
    logic [31:0]      width_reg,  width_next;
    logic [31:0]      height_reg, height_next;
    bmpd_pkg::phase_t phase_reg,  phase_next;
    logic [7:0]       blue_reg,   blue_next;
    logic [7:0]       green_reg,  green_next;
    logic [13:0]      col_reg,    col_next;
    logic [13:0]      frow_reg,   frow_next;
    logic [1:0]       pad_reg,    pad_next;
    bmpd_pkg::mode_t  mode_reg,   mode_next;

    // state as seen by this word, after a possible restart
    logic [5:0]       hc_cur;
    logic [31:0]      width_cur;
    logic [31:0]      height_cur;
    bmpd_pkg::phase_t phase_cur;
    logic [7:0]       blue_cur;
    logic [7:0]       green_cur;
    logic [13:0]      col_cur;
    logic [13:0]      frow_cur;
    logic [1:0]       pad_cur;
    bmpd_pkg::mode_t  mode_cur;

    logic [7:0]  b;
    logic [1:0]  lane;
    logic [14:0] w_m1;
    logic [14:0] h_m1;
    logic        row_end;
    logic        last;
    logic        too_big;
    logic [1:0]  pad_inc;

    assign accept      = bytes.valid && space;
    assign bytes.ready = space;
    assign b           = bytes.data.data_byte;

    always_comb
    begin
        if (bytes.data.start_of_file)
        begin
            hc_cur     = '0;
            width_cur  = '0;
            height_cur = '0;
            phase_cur  = bmpd_pkg::PHASE_BLUE;
            blue_cur   = '0;
            green_cur  = '0;
            col_cur    = '0;
            frow_cur   = '0;
            pad_cur    = '0;
            mode_cur   = bmpd_pkg::MODE_HEADER;
        end
        else
        begin
            hc_cur     = hc_reg;
            width_cur  = width_reg;
            height_cur = height_reg;
            phase_cur  = phase_reg;
            blue_cur   = blue_reg;
            green_cur  = green_reg;
            col_cur    = col_reg;
            frow_cur   = frow_reg;
            pad_cur    = pad_reg;
            mode_cur   = mode_reg;
        end
    end

    always_comb
    begin
        hc_next     = hc_cur;
        width_next  = width_cur;
        height_next = height_cur;
        phase_next  = phase_cur;
        blue_next   = blue_cur;
        green_next  = green_cur;
        col_next    = col_cur;
        frow_next   = frow_cur;
        pad_next    = pad_cur;
        mode_next   = mode_cur;

        lane    = '0;
        pad_inc = pad_cur + 2'd1;
        w_m1    = width_cur[14:0] - 15'd1;
        h_m1    = height_cur[14:0] - 15'd1;
        row_end = ({1'b0, col_cur} == w_m1);
        last    = row_end && ({1'b0, frow_cur} == h_m1);
        too_big = 1'b0;

        res_valid = 1'b0;
        res       = '0;

        unique case (mode_cur)
            bmpd_pkg::MODE_HEADER:
            begin
                // little-endian size fields land one byte lane at a time
                if (hc_cur >= bmpd_pkg::WIDTH_LO && hc_cur < bmpd_pkg::WIDTH_HI)
                begin
                    lane = 2'(hc_cur - bmpd_pkg::WIDTH_LO);
                    width_next[{lane, 3'b000} +: 8] = b;
                end
                else if (hc_cur >= bmpd_pkg::HEIGHT_LO && hc_cur < bmpd_pkg::HEIGHT_HI)
                begin
                    lane = 2'(hc_cur - bmpd_pkg::HEIGHT_LO);
                    height_next[{lane, 3'b000} +: 8] = b;
                end
                hc_next = hc_cur + 6'd1;
                if (hc_cur == bmpd_pkg::HDR_LAST)
                begin
                    too_big = (width_next > bmpd_pkg::MAX_DIM) ||
                              (height_next > bmpd_pkg::MAX_DIM);
                    res_valid = 1'b1;
                    if (too_big)
                    begin
                        res.kind  = bmpd_pkg::KIND_ERROR;
                        mode_next = bmpd_pkg::MODE_DONE;
                    end
                    else
                    begin
                        res.kind = bmpd_pkg::KIND_HEADER;
                        if (width_next == '0 || height_next == '0)
                        begin
                            mode_next = bmpd_pkg::MODE_DONE;
                        end
                        else
                        begin
                            mode_next = bmpd_pkg::MODE_PIXEL;
                        end
                    end
                end
            end
            bmpd_pkg::MODE_PIXEL:
            begin
                case (phase_cur)
                    bmpd_pkg::PHASE_BLUE:
                    begin
                        blue_next  = b;
                        phase_next = bmpd_pkg::PHASE_GREEN;
                    end
                    bmpd_pkg::PHASE_GREEN:
                    begin
                        green_next = b;
                        phase_next = bmpd_pkg::PHASE_RED;
                    end
                    default:
                    begin
                        phase_next         = bmpd_pkg::PHASE_BLUE;
                        res_valid          = 1'b1;
                        res.kind           = bmpd_pkg::KIND_PIXEL;
                        res.red            = b;
                        res.green          = green_cur;
                        res.blue           = blue_cur;
                        res.packed_color   = {b, green_cur, blue_cur};
                        res.column         = col_cur;
                        // rows are stored bottom-up in the file
                        res.row            = 14'(h_m1 - {1'b0, frow_cur});
                        res.last_pixel     = last;
                        if (last)
                        begin
                            mode_next = bmpd_pkg::MODE_DONE;
                        end
                        else if (row_end)
                        begin
                            col_next  = '0;
                            frow_next = frow_cur + 14'd1;
                            if (width_cur[1:0] != 2'd0)
                            begin
                                pad_next  = '0;
                                mode_next = bmpd_pkg::MODE_PAD;
                            end
                        end
                        else
                        begin
                            col_next = col_cur + 14'd1;
                        end
                    end
                endcase
            end
            bmpd_pkg::MODE_PAD:
            begin
                if (pad_inc >= width_cur[1:0])
                begin
                    pad_next  = '0;
                    mode_next = bmpd_pkg::MODE_PIXEL;
                end
                else
                begin
                    pad_next = pad_inc;
                end
            end
            default:
            begin
                // image done or rejected: wait for the next start of file
            end
        endcase

        res.image_width  = bmpd_pkg::sat_dim(width_next);
        res.image_height = bmpd_pkg::sat_dim(height_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg     <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            phase_reg  <= bmpd_pkg::PHASE_BLUE;
            blue_reg   <= '0;
            green_reg  <= '0;
            col_reg    <= '0;
            frow_reg   <= '0;
            pad_reg    <= '0;
            mode_reg   <= bmpd_pkg::MODE_HEADER;
        end
        else if (accept)
        begin
            hc_reg     <= hc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            phase_reg  <= phase_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            col_reg    <= col_next;
            frow_reg   <= frow_next;
            pad_reg    <= pad_next;
            mode_reg   <= mode_next;
        end
    end

endmodule

FILE: hw/rtl/bmpd_out_reg.sv
// bmpd_out_reg: result register driving the output channel
// depends on bmpd_pkg and bmpd_out_if

module bmpd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic                 res_valid,
    input  bmpd_pkg::out_word_t  res,
    output logic                 space,
    bmpd_out_if.source           results
);

    logic                valid_reg, valid_next;
    bmpd_pkg::out_word_t data_reg;

    // a new word may enter when the register is empty or draining this cycle
    assign space         = !valid_reg || results.ready;
    assign valid_next    = take ? res_valid : (valid_reg && !results.ready);
    assign results.valid = valid_reg;
    assign results.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

FILE: hw/rtl/bmp24_stream_decoder.sv
// bmp24_stream_decoder: streaming decoder for 24-bit bitmap files
// a result word is registered and becomes valid in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle while the result register has space (empty or draining)
// a byte is taken while a result waits, as long as the result register drains that cycle
// reset (rst_n, async, active low) empties the result register and restarts at header byte 0
// depends on bmpd_pkg, bmpd_in_if, bmpd_out_if, bmpd_parse, bmpd_out_reg

module bmp24_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    bmpd_in_if.sink     bytes,
    bmpd_out_if.source  results
);

    logic                space;
    logic                accept;
    logic                res_valid;
    bmpd_pkg::out_word_t res;

    bmpd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .space     (space),
        .accept    (accept),
        .res_valid (res_valid),
        .res       (res)
    );

    bmpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (accept),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .results   (results)
    );

endmodule

FILE: tb/sv/bmp24_stream_decoder_tb.sv
// bmp24_stream_decoder_tb: self-checking bench for the streaming 24-bit bitmap decoder
// feeds bitmap files one byte per word and checks every result word against a local decoder
// depends on bmpd_pkg, bmpd_in_if, bmpd_out_if and the decoder rtl

module bmp24_stream_decoder_tb;

    logic clk;
    logic rst_n;
    bit   calm;
    int   fails;

    bmpd_in_if  bytes_if ();
    bmpd_out_if results_if ();

    bmp24_stream_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (results_if)
    );

    // decoder state as the bench tracks it
    int unsigned          hdr_cnt;
    logic [31:0]          img_w;
    logic [31:0]          img_h;
    bmpd_pkg::phase_t     phase;
    logic [7:0]           held_b;
    logic [7:0]           held_g;
    logic [31:0]          col;
    logic [31:0]          frow;
    logic [31:0]          pad_seen;
    bmpd_pkg::mode_t      parse_state;

    bmpd_pkg::out_word_t  pending_results[$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void restart_parse();
        hdr_cnt     = 0;
        img_w       = '0;
        img_h       = '0;
        phase       = bmpd_pkg::PHASE_BLUE;
        held_b      = '0;
        held_g      = '0;
        col         = '0;
        frow        = '0;
        pad_seen    = '0;
        parse_state = bmpd_pkg::MODE_HEADER;
    endfunction

    function automatic logic [14:0] clip_dim(input logic [31:0] v);
        return (v > bmpd_pkg::MAX_DIM) ? 15'd16384 : v[14:0];
    endfunction

    // advance the decoder by one byte and report the result word it makes, if any
    function automatic void decode_byte(input logic [7:0] b, input logic sof,
                                        output bit produced, output bmpd_pkg::out_word_t w);
        bit row_end;
        bit last;
        produced = 1'b0;
        w = '0;
        if (sof)
            restart_parse();
        case (parse_state)
            bmpd_pkg::MODE_HEADER:
            begin
                if (hdr_cnt >= bmpd_pkg::WIDTH_OFS && hdr_cnt < bmpd_pkg::WIDTH_OFS + 4)
                    img_w |= 32'(b) << (8 * (hdr_cnt - bmpd_pkg::WIDTH_OFS));
                else if (hdr_cnt >= bmpd_pkg::HEIGHT_OFS && hdr_cnt < bmpd_pkg::HEIGHT_OFS + 4)
                    img_h |= 32'(b) << (8 * (hdr_cnt - bmpd_pkg::HEIGHT_OFS));
                hdr_cnt++;
                if (hdr_cnt == bmpd_pkg::HEADER_BYTES)
                begin
                    produced = 1'b1;
                    w.image_width  = clip_dim(img_w);
                    w.image_height = clip_dim(img_h);
                    if (img_w > bmpd_pkg::MAX_DIM || img_h > bmpd_pkg::MAX_DIM)
                    begin
                        w.kind = bmpd_pkg::KIND_ERROR;
                        parse_state = bmpd_pkg::MODE_DONE;
                    end
                    else
                    begin
                        w.kind = bmpd_pkg::KIND_HEADER;
                        parse_state = (img_w == 0 || img_h == 0) ? bmpd_pkg::MODE_DONE
                                                                 : bmpd_pkg::MODE_PIXEL;
                    end
                end
            end
            bmpd_pkg::MODE_PIXEL:
            begin
                if (phase == bmpd_pkg::PHASE_BLUE)
                begin
                    held_b = b;
                    phase = bmpd_pkg::PHASE_GREEN;
                end
                else if (phase == bmpd_pkg::PHASE_GREEN)
                begin
                    held_g = b;
                    phase = bmpd_pkg::PHASE_RED;
                end
                else
                begin
                    phase = bmpd_pkg::PHASE_BLUE;
                    produced = 1'b1;
                    w.kind         = bmpd_pkg::KIND_PIXEL;
                    w.red          = b;
                    w.green        = held_g;
                    w.blue         = held_b;
                    w.packed_color = {b, held_g, held_b};
                    w.column       = col[13:0];
                    w.row          = 14'(img_h - 32'd1 - frow);
                    w.image_width  = clip_dim(img_w);
                    w.image_height = clip_dim(img_h);
                    row_end = (col == img_w - 32'd1);
                    last = row_end && (frow == img_h - 32'd1);
                    w.last_pixel = last;
                    if (last)
                        parse_state = bmpd_pkg::MODE_DONE;
                    else if (row_end)
                    begin
                        col = '0;
                        frow++;
                        if (img_w[1:0] != 2'd0)
                        begin
                            pad_seen = '0;
                            parse_state = bmpd_pkg::MODE_PAD;
                        end
                    end
                    else
                        col++;
                end
            end
            bmpd_pkg::MODE_PAD:
            begin
                pad_seen++;
                if (pad_seen >= {30'd0, img_w[1:0]})
                begin
                    pad_seen = '0;
                    parse_state = bmpd_pkg::MODE_PIXEL;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // result side: random backpressure, checked at the falling edge before the word is taken
    always @(posedge clk)
        results_if.ready <= calm || ($urandom_range(99) >= 6);

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(negedge clk)
    begin : check_results
        bmpd_pkg::out_word_t want;
        bmpd_pkg::out_word_t got;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            got = results_if.data;
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected: kind %0d", got.kind);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind",         32'(want.kind),       32'(got.kind));
                check_field("red",          32'(want.red),        32'(got.red));
                check_field("green",        32'(want.green),      32'(got.green));
                check_field("blue",         32'(want.blue),       32'(got.blue));
                check_field("packed_color", 32'(want.packed_color), 32'(got.packed_color));
                check_field("column",       32'(want.column),     32'(got.column));
                check_field("row",          32'(want.row),        32'(got.row));
                check_field("last_pixel",   32'(want.last_pixel), 32'(got.last_pixel));
                check_field("image_width",  32'(want.image_width), 32'(got.image_width));
                check_field("image_height", 32'(want.image_height), 32'(got.image_height));
            end
        end
    end

    int bytes_sent;

    // one file byte, with an occasional gap in front of it
    task automatic send_byte(input logic [7:0] b, input logic sof);
        bit                  taken;
        bit                  produced;
        bmpd_pkg::out_word_t w;
        if (!calm && $urandom_range(99) < 6)
        begin
            bytes_if.valid <= 1'b0;
            @(posedge clk);
        end
        bytes_if.valid <= 1'b1;
        bytes_if.data  <= '{data_byte: b, start_of_file: sof};
        do
        begin
            @(negedge clk);
            taken = bytes_if.ready;
            @(posedge clk);
        end
        while (!taken);
        decode_byte(b, sof, produced, w);
        if (produced)
            pending_results.push_back(w);
        bytes_sent++;
    endtask

    // first n bytes of a header with the given size fields, the rest random
    task automatic send_header(input logic [31:0] w, input logic [31:0] h,
                               input bit sof, input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            if (i >= bmpd_pkg::WIDTH_OFS && i < bmpd_pkg::WIDTH_OFS + 4)
                b = w[8 * (i - bmpd_pkg::WIDTH_OFS) +: 8];
            else if (i >= bmpd_pkg::HEIGHT_OFS && i < bmpd_pkg::HEIGHT_OFS + 4)
                b = h[8 * (i - bmpd_pkg::HEIGHT_OFS) +: 8];
            send_byte(b, sof && i == 0);
        end
    endtask

    // pixel rows with row padding; fill below zero means random bytes
    task automatic send_pixels(input int w, input int rows, input int fill);
        for (int r = 0; r < rows; r++)
        begin
            for (int i = 0; i < 3 * w; i++)
                send_byte((fill < 0) ? 8'($urandom) : 8'(fill), 1'b0);
            for (int p = 0; p < w % 4; p++)
                send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic drain_results();
        bytes_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // parse runs from reset without a start marker; bytes after the last pixel are dropped
    task automatic test_headerless_start();
        send_header(32'd2, 32'd2, 1'b0, bmpd_pkg::HEADER_BYTES);
        send_pixels(2, 2, 8'hFF);
        send_noise(3);
    endtask

    task automatic test_padding();
        send_header(32'd3, 32'd2, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_pixels(3, 2, 8'h00);
        send_header(32'd5, 32'd1, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_pixels(5, 1, -1);
    endtask

    task automatic test_empty_images();
        send_header(32'd0, 32'd4, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_noise(4);
        send_header(32'd5, 32'd0, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_header(32'd0, 32'd0, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_noise(6);
    endtask

    task automatic test_oversize();
        send_header(32'd16385, 32'd1, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_noise(6);
        send_header(32'd1, 32'h8000_0000, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_header(32'd16384, 32'd16385, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_noise(3);
    endtask

    // start marker lands mid-header, mid-pixel and right after a row's padding
    task automatic test_restart();
        send_header(32'd4, 32'd3, 1'b1, 20);
        send_header(32'd4, 32'd3, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_noise(7);
        send_header(32'd1, 32'd3, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_noise(4);
        send_header(32'd1, 32'd1, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_pixels(1, 1, -1);
    endtask

    // widest and tallest images cut short, with the sender held until idle
    task automatic test_max_dims();
        calm = 1'b1;
        send_header(32'd16384, 32'd1, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_noise(3 * 8);
        calm = 1'b0;
        drain_results();
        send_header(32'd1, 32'd16384, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_pixels(1, 2, -1);
        send_header(32'd16384, 32'd16384, 1'b1, bmpd_pkg::HEADER_BYTES);
        send_pixels(2, 1, -1);
    endtask

    task automatic test_random_files();
        int          first;
        int          pick;
        logic [31:0] w;
        logic [31:0] h;
        first = bytes_sent;
        while (bytes_sent - first < 300)
        begin
            calm = (bytes_sent - first) >= 75 && (bytes_sent - first) < 225;
            pick = $urandom_range(99);
            w = $urandom_range(0, 6);
            h = $urandom_range(0, 4);
            if (pick < 70)
            begin
                send_header(w, h, 1'b1, bmpd_pkg::HEADER_BYTES);
                send_pixels(w, h, -1);
                if ($urandom_range(3) == 0)
                    send_noise($urandom_range(1, 5));
            end
            else if (pick < 80)
            begin
                w = $urandom;
                h = ($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 3);
                send_header(w, h, 1'b1, bmpd_pkg::HEADER_BYTES);
            end
            else if (pick < 90)
            begin
                send_header(w, h, 1'b1, $urandom_range(1, bmpd_pkg::HEADER_BYTES - 1));
            end
            else
            begin
                send_header(w + 1, h + 1, 1'b1, bmpd_pkg::HEADER_BYTES);
                send_noise($urandom_range(1, 3 * (w + 1) * (h + 1)));
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        calm           = 1'b0;
        fails          = 0;
        bytes_sent     = 0;
        bytes_if.valid = 1'b0;
        bytes_if.data  = '0;
        restart_parse();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_headerless_start();
        test_padding();
        test_empty_images();
        test_oversize();
        test_restart();
        test_max_dims();
        test_random_files();

        drain_results();
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/bmpd_pkg.sv
hw/rtl/bmpd_in_if.sv
hw/rtl/bmpd_out_if.sv
hw/rtl/bmpd_parse.sv
hw/rtl/bmpd_out_reg.sv
hw/rtl/bmp24_stream_decoder.sv
tb/sv/bmp24_stream_decoder_tb.sv
